// ===== src/whps_pkg.sv =====
// Shared types, constants and the arctangent table for the waypoint heading PD steering block.
`timescale 1ns / 1ps

package whps_pkg;

	// defaults for the top-level parameters
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ERROR_FRAC_DEF   = 8;

	// port widths
	localparam int POS_W    = 40;
	localparam int HEAD_W   = 16;
	localparam int GAIN_W   = 16;
	localparam int REM_W    = 9;                // |steer| < 360
	localparam int STEER_W  = REM_W + 1;
	localparam int APB_W    = 32;
	localparam int ADDR_W   = 3;
	localparam int REG_SEL_BIT = 2;

	// CORDIC datapath
	localparam int DIFF_W    = POS_W + 1;       // goal - pose
	localparam int XY_W      = 44;              // covers CORDIC gain on a 41-bit vector
	localparam int Z_W       = 64;              // radians, 60 fraction bits
	localparam int ROM_SIZE  = 32;
	localparam int ROM_IDX_W = 5;
	localparam int HEAD_SHIFT = 47;             // Q2.13 -> Q60
	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

	// radians to degrees
	localparam int RND_SHIFT = 30;
	localparam int M30_W     = 32;
	localparam int DEG_SCALE = 180;
	localparam int DEG_INT_W = 8;               // 180 fits in 8 bits
	localparam int ERR_INT_W = DEG_INT_W + 2;   // sign plus headroom for the error word
	localparam logic [M30_W-1:0] DEG_DEN  = PI_Q60[RND_SHIFT+M30_W-1:RND_SHIFT];
	localparam logic [M30_W-1:0] DEG_HALF = {1'b0, DEG_DEN[M30_W-1:1]};

	// PD law, rounding, saturation and the remainder by 360
	localparam int GAIN_FRAC = 8;
	localparam int SAT_MAX   = 32767;
	localparam int SAT_MIN   = -32768;
	localparam int MAG_W     = 16;
	localparam logic [MAG_W-1:0] SAT_NEG_MAG = 16'h8000;
	localparam int MOD_DIV     = 360;
	localparam int RECIP_SHIFT = 24;
	localparam logic [MAG_W-1:0] RECIP_MUL =
		16'(((1 << RECIP_SHIFT) + MOD_DIV - 1) / MOD_DIV);
	localparam int QUOT_W = 8;

	typedef enum logic {
		REG_PROP_GAIN  = 1'b0,
		REG_DERIV_GAIN = 1'b1
	} reg_idx_t;

	typedef logic [ROM_SIZE-1:0][Z_W-1:0] atan_tab_t;

	// bit-by-bit long division, elaboration only
	function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// atan(2^-i) in Q60 from the truncated arctangent series
	function automatic atan_tab_t build_atan_tab();
		atan_tab_t   tab;
		logic [63:0] sum;
		logic [63:0] term;
		int          sh;
		tab    = '0;
		tab[0] = PI_Q60 >> 2;
		for (int i = 1; i < ROM_SIZE; i++) begin
			sum = '0;
			for (int k = 0; k < 31; k++) begin
				sh = i * (2 * k + 1);
				if (sh <= 60) begin
					term = long_div(64'd1 << (60 - sh), 64'(2 * k + 1));
					if (k % 2 == 1) begin
						sum = sum - term;
					end else begin
						sum = sum + term;
					end
				end
			end
			tab[i] = sum;
		end
		return tab;
	endfunction

	localparam atan_tab_t ATAN_TAB = build_atan_tab();

endpackage

// ===== src/whps_cordic.sv =====
// Iterative CORDIC vectoring unit: bearing of the goal offset minus heading, wrapped to (-pi, pi].
`timescale 1ns / 1ps

module whps_cordic
	import whps_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DIFF_W-1:0] dx,
	input  logic signed [DIFF_W-1:0] dy,
	input  logic signed [HEAD_W-1:0] heading,
	output logic                     done,
	output logic signed [Z_W-1:0]    bearing
);

	localparam int N_ITER = (CORDIC_STEPS > ROM_SIZE) ? ROM_SIZE : CORDIC_STEPS;
	localparam int ITER_W = (N_ITER > 1) ? $clog2(N_ITER) : 1;
	localparam int B_W    = Z_W + 2;
	localparam logic signed [Z_W-1:0] PI_S     = PI_Q60;
	localparam logic signed [B_W-1:0] PI_B     = B_W'(PI_S);
	localparam logic signed [B_W-1:0] NEG_PI_B = -PI_B;
	localparam logic signed [B_W-1:0] TWO_PI_B = PI_B <<< 1;

	typedef enum logic [1:0] {S_IDLE, S_ROT, S_SUB, S_WRAP} state_t;

	state_t                   state_q;
	logic [ITER_W-1:0]        iter_q;
	logic signed [XY_W-1:0]   x_q, y_q;
	logic signed [Z_W-1:0]    z_q;
	logic signed [HEAD_W-1:0] head_q;
	logic                     zero_q;
	logic signed [B_W-1:0]    b_q;
	logic signed [Z_W-1:0]    bearing_q;
	logic                     done_q;

	logic signed [XY_W-1:0]   dx_ext, dy_ext, x_sh, y_sh;
	logic signed [Z_W-1:0]    atan_val;
	logic signed [B_W-1:0]    b_raw, b_wrap;

	assign dx_ext   = XY_W'(dx);
	assign dy_ext   = XY_W'(dy);
	assign x_sh     = x_q >>> iter_q;
	assign y_sh     = y_q >>> iter_q;
	assign atan_val = ATAN_TAB[ROM_IDX_W'(iter_q)];
	assign b_raw    = B_W'(z_q) - (B_W'(head_q) <<< HEAD_SHIFT);

	always_comb begin
		if (b_q > PI_B) begin
			b_wrap = b_q - TWO_PI_B;
		end else if (b_q <= NEG_PI_B) begin
			b_wrap = b_q + TWO_PI_B;
		end else begin
			b_wrap = b_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			iter_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						zero_q <= (dx == '0) && (dy == '0);
						head_q <= heading;
						iter_q <= '0;
						// left half plane: turn the vector by pi first
						if (dx < 0) begin
							x_q <= -dx_ext;
							y_q <= -dy_ext;
							z_q <= (dy >= 0) ? PI_S : -PI_S;
						end else begin
							x_q <= dx_ext;
							y_q <= dy_ext;
							z_q <= '0;
						end
						state_q <= S_ROT;
					end
				end
				S_ROT: begin
					if (y_q >= 0) begin
						x_q <= x_q + y_sh;
						y_q <= y_q - x_sh;
						z_q <= z_q + atan_val;
					end else begin
						x_q <= x_q - y_sh;
						y_q <= y_q + x_sh;
						z_q <= z_q - atan_val;
					end
					iter_q <= iter_q + 1'b1;
					if (iter_q == ITER_W'(N_ITER - 1)) begin
						state_q <= S_SUB;
					end
				end
				S_SUB: begin
					b_q     <= b_raw;
					state_q <= S_WRAP;
				end
				S_WRAP: begin
					bearing_q <= zero_q ? '0 : Z_W'(b_wrap);
					done_q    <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done    = done_q;
	assign bearing = bearing_q;

endmodule

// ===== src/whps_deg.sv =====
// Bearing to degrees: magnitude rounding, scale by 180 and a reciprocal divide by pi.
`timescale 1ns / 1ps

module whps_deg
	import whps_pkg::*;
#(
	parameter int ERROR_FRAC_BITS = ERROR_FRAC_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [Z_W-1:0] bearing,
	output logic                  done,
	output logic signed [ERROR_FRAC_BITS+ERR_INT_W-1:0] err
);

	localparam int Q_W     = ERROR_FRAC_BITS + DEG_INT_W;
	localparam int E_W     = ERROR_FRAC_BITS + ERR_INT_W;
	localparam int NUM_W   = M30_W + DEG_INT_W + ERROR_FRAC_BITS + 1;
	localparam int BMAG_W  = Z_W - 1;
	localparam int P_W     = 2 * M30_W;
	localparam int K_SHIFT = P_W - DEG_INT_W;
	localparam int RW      = M30_W + 2;
	localparam logic [BMAG_W-1:0] RND_HALF = BMAG_W'(1) << (RND_SHIFT - 1);
	// 180 / pi scaled by 2^K_SHIFT, fits 32 bits
	localparam logic [M30_W-1:0] DEG_RECIP =
		M30_W'((96'(DEG_SCALE) << K_SHIFT) / 96'(DEG_DEN));
	localparam logic [RW-1:0] DEN_R = RW'(DEG_DEN);

	typedef enum logic [2:0] {
		S_IDLE, S_RND, S_EST, S_REM, S_FIX_A, S_FIX_B, S_SIGN
	} state_t;

	state_t                  state_q;
	logic                    neg_q;
	logic [BMAG_W-1:0]       mag_q;
	logic [M30_W-1:0]        m30_q;
	logic [NUM_W-1:0]        num_q;
	logic [RW-1:0]           rem_q;
	logic [Q_W-1:0]          quo_q;
	logic signed [E_W-1:0]   err_q;
	logic                    done_q;

	logic [NUM_W-1:0]        num;
	logic [P_W-1:0]          est_p;
	logic                    fix_ge;
	logic signed [E_W-1:0]   quo_ext;

	// (m30 * 180) << frac, plus half the divisor for round half up
	assign num     = ((NUM_W'(m30_q) * NUM_W'(DEG_SCALE)) << ERROR_FRAC_BITS)
		+ NUM_W'(DEG_HALF);
	// quotient estimate is at most two below the rounded quotient
	assign est_p   = P_W'(m30_q) * P_W'(DEG_RECIP);
	assign fix_ge  = (rem_q >= DEN_R);
	assign quo_ext = signed'({2'b00, quo_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						neg_q   <= bearing[Z_W-1];
						mag_q   <= BMAG_W'(bearing[Z_W-1] ? -bearing : bearing);
						state_q <= S_RND;
					end
				end
				S_RND: begin
					m30_q   <= M30_W'((mag_q + RND_HALF) >> RND_SHIFT);
					state_q <= S_EST;
				end
				S_EST: begin
					quo_q   <= est_p[K_SHIFT-ERROR_FRAC_BITS+Q_W-1:K_SHIFT-ERROR_FRAC_BITS];
					num_q   <= num;
					state_q <= S_REM;
				end
				S_REM: begin
					rem_q   <= RW'(num_q - NUM_W'(quo_q) * NUM_W'(DEG_DEN));
					state_q <= S_FIX_A;
				end
				S_FIX_A, S_FIX_B: begin
					// two compare-and-subtract steps close the estimate gap
					if (fix_ge) begin
						rem_q <= rem_q - DEN_R;
						quo_q <= quo_q + 1'b1;
					end
					state_q <= (state_q == S_FIX_A) ? S_FIX_B : S_SIGN;
				end
				S_SIGN: begin
					err_q   <= neg_q ? -quo_ext : quo_ext;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign err  = err_q;

endmodule

// ===== src/whps_pd.sv =====
// PD law on the degree error with one shared multiplier, rounding, saturation and remainder by 360.
`timescale 1ns / 1ps

module whps_pd
	import whps_pkg::*;
#(
	parameter int ERROR_FRAC_BITS = ERROR_FRAC_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [ERROR_FRAC_BITS+ERR_INT_W-1:0] err,
	input  logic signed [GAIN_W-1:0]  prop_gain,
	input  logic signed [GAIN_W-1:0]  deriv_gain,
	output logic                      done,
	output logic signed [STEER_W-1:0] steer,
	output logic                      locked
);

	localparam int E_W    = ERROR_FRAC_BITS + ERR_INT_W;
	localparam int DE_W   = E_W + 1;
	localparam int PROD_W = GAIN_W + DE_W;
	localparam int ACC_W  = PROD_W + 1;
	localparam int FB     = GAIN_FRAC + ERROR_FRAC_BITS;
	localparam int SH_W   = ACC_W - FB;
	localparam int RP_W   = 2 * MAG_W;
	localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (FB - 1);
	localparam logic signed [ACC_W-1:0] ONE_M1   = (ACC_W'(1) <<< FB) - ACC_W'(1);
	localparam logic signed [E_W-1:0]   LOCK_POS = E_W'(2) <<< ERROR_FRAC_BITS;
	localparam logic signed [E_W-1:0]   LOCK_NEG = -LOCK_POS;
	localparam logic signed [SH_W-1:0]  SAT_HI   = SH_W'(SAT_MAX);
	localparam logic signed [SH_W-1:0]  SAT_LO   = SH_W'(SAT_MIN);

	typedef enum logic [3:0] {
		S_IDLE, S_MUL_D, S_SUM, S_HALF, S_TRUNC, S_SAT, S_RECIP, S_REM, S_SIGN
	} state_t;

	state_t                     state_q;
	logic signed [E_W-1:0]      prev_q;
	logic signed [DE_W-1:0]     diff_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic                       neg_q;
	logic [MAG_W-1:0]           mag_q;
	logic [QUOT_W-1:0]          quot_q;
	logic [REM_W-1:0]           rem_q;
	logic signed [STEER_W-1:0]  steer_q;
	logic                       locked_q;
	logic                       done_q;

	logic signed [GAIN_W-1:0]   mul_a;
	logic signed [DE_W-1:0]     mul_b;
	logic signed [PROD_W-1:0]   mul_p;
	logic signed [SH_W-1:0]     sh_v;
	logic [RP_W-1:0]            recip_p;
	logic signed [STEER_W-1:0]  rem_ext;

	// proportional term on the start cycle, derivative term after
	assign mul_a   = (state_q == S_IDLE) ? prop_gain : deriv_gain;
	assign mul_b   = (state_q == S_IDLE) ? DE_W'(err) : diff_q;
	assign mul_p   = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign sh_v    = SH_W'(acc_q >>> FB);
	assign recip_p = RP_W'(mag_q) * RP_W'(RECIP_MUL);
	assign rem_ext = signed'({1'b0, rem_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			prev_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						prod_q   <= mul_p;
						diff_q   <= DE_W'(err) - DE_W'(prev_q);
						prev_q   <= err;
						locked_q <= (err >= LOCK_NEG) && (err <= LOCK_POS);
						state_q  <= S_MUL_D;
					end
				end
				S_MUL_D: begin
					acc_q   <= ACC_W'(prod_q);
					prod_q  <= mul_p;
					state_q <= S_SUM;
				end
				S_SUM: begin
					acc_q   <= acc_q + ACC_W'(prod_q);
					state_q <= S_HALF;
				end
				S_HALF: begin
					acc_q   <= acc_q + RND_HALF;
					state_q <= S_TRUNC;
				end
				S_TRUNC: begin
					// bias negatives so the shift truncates toward zero
					acc_q   <= acc_q + ((acc_q < 0) ? ONE_M1 : '0);
					state_q <= S_SAT;
				end
				S_SAT: begin
					neg_q <= (sh_v < 0);
					if (sh_v < SAT_LO) begin
						mag_q <= SAT_NEG_MAG;
					end else if (sh_v < 0) begin
						mag_q <= MAG_W'(-sh_v);
					end else if (sh_v > SAT_HI) begin
						mag_q <= MAG_W'(SAT_MAX);
					end else begin
						mag_q <= MAG_W'(sh_v);
					end
					state_q <= S_RECIP;
				end
				S_RECIP: begin
					quot_q  <= recip_p[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
					state_q <= S_REM;
				end
				S_REM: begin
					rem_q   <= REM_W'(mag_q - MAG_W'(quot_q) * MAG_W'(MOD_DIV));
					state_q <= S_SIGN;
				end
				S_SIGN: begin
					steer_q <= neg_q ? -rem_ext : rem_ext;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign steer  = steer_q;
	assign locked = locked_q;

endmodule

// ===== src/waypoint_heading_pd_steering_core.sv =====
// Top level of the waypoint heading PD steering block: APB registers, request control, result register.
//
// Usage:
//   Input channel (in_valid / in_ready) carries one request per control tick: the pose
//   (pose_x, pose_y, pose_heading) and the waypoint (goal_x, goal_y). Output channel
//   (out_valid / out_ready) returns steer_command in whole degrees and heading_locked.
//   The APB port holds prop_gain at 0x0 and deriv_gain at 0x4 (signed Q7.8, low 16 bits
//   of pwdata); pready is tied high. Write the gains only while no request is in flight.
// Flow: CORDIC_STEPS sets the number of CORDIC micro-rotations (values above 32
//   count as 32). One request is in flight at a time; in_ready is low while it runs
//   and returns as its result is loaded into the output register, so a new request
//   is not taken before the last one is through. A request passes through the
//   CORDIC iteration loop (one micro-rotation a cycle), then reciprocal multiply,
//   correction, PD and rounding steps.
// Stall: the result sits in the output register until taken. A new request may be
//   accepted meanwhile; its result waits inside the PD unit until the register frees.
// Reset: arst_n clears all control, the previous error and restores the default gains.
`timescale 1ns / 1ps

module waypoint_heading_pd_steering_core
	import whps_pkg::*;
#(
	parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
	parameter int ERROR_FRAC_BITS = ERROR_FRAC_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// APB configuration
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ADDR_W-1:0]         paddr,
	input  logic [APB_W-1:0]          pwdata,
	output logic [APB_W-1:0]          prdata,
	output logic                      pready,
	// request channel
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [POS_W-1:0]   pose_x,
	input  logic signed [POS_W-1:0]   pose_y,
	input  logic signed [HEAD_W-1:0]  pose_heading,
	input  logic signed [POS_W-1:0]   goal_x,
	input  logic signed [POS_W-1:0]   goal_y,
	// result channel
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [STEER_W-1:0] steer_command,
	output logic                      heading_locked
);

	localparam int E_W = ERROR_FRAC_BITS + ERR_INT_W;
	localparam logic signed [GAIN_W-1:0] PROP_RST  = 16'sd128;
	localparam logic signed [GAIN_W-1:0] DERIV_RST = 16'sd1536;

	typedef enum logic [1:0] {S_IDLE, S_BUSY, S_HOLD} state_t;

	state_t                     state_q;
	logic signed [GAIN_W-1:0]   prop_gain_q, deriv_gain_q;
	logic                       out_valid_q;
	logic signed [STEER_W-1:0]  steer_q;
	logic                       locked_q;

	logic                       in_fire, wr_en, out_free;
	logic signed [DIFF_W-1:0]   dx, dy;
	logic                       cordic_done, deg_done, pd_done;
	logic signed [Z_W-1:0]      bearing;
	logic signed [E_W-1:0]      err;
	logic signed [STEER_W-1:0]  pd_steer;
	logic                       pd_locked;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign dx       = DIFF_W'(goal_x) - DIFF_W'(pose_x);
	assign dy       = DIFF_W'(goal_y) - DIFF_W'(pose_y);

	// configuration registers
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= PROP_RST;
			deriv_gain_q <= DERIV_RST;
		end else if (wr_en) begin
			case (reg_idx_t'(paddr[REG_SEL_BIT]))
				REG_PROP_GAIN:  prop_gain_q  <= pwdata[GAIN_W-1:0];
				REG_DERIV_GAIN: deriv_gain_q <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[REG_SEL_BIT]))
			REG_PROP_GAIN:  prdata = APB_W'(prop_gain_q);
			REG_DERIV_GAIN: prdata = APB_W'(deriv_gain_q);
			default:        prdata = '0;
		endcase
	end

	// bearing -> degrees -> PD, each stage kicks the next on its done pulse
	whps_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_fire),
		.dx      (dx),
		.dy      (dy),
		.heading (pose_heading),
		.done    (cordic_done),
		.bearing (bearing)
	);

	whps_deg #(
		.ERROR_FRAC_BITS(ERROR_FRAC_BITS)
	) u_deg (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cordic_done),
		.bearing (bearing),
		.done    (deg_done),
		.err     (err)
	);

	whps_pd #(
		.ERROR_FRAC_BITS(ERROR_FRAC_BITS)
	) u_pd (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (deg_done),
		.err        (err),
		.prop_gain  (prop_gain_q),
		.deriv_gain (deriv_gain_q),
		.done       (pd_done),
		.steer      (pd_steer),
		.locked     (pd_locked)
	);

	// request sequencing and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_BUSY;
					end
				end
				S_BUSY: begin
					if (pd_done) begin
						if (out_free) begin
							out_valid_q <= 1'b1;
							steer_q     <= pd_steer;
							locked_q    <= pd_locked;
							state_q     <= S_IDLE;
						end else begin
							state_q <= S_HOLD;
						end
					end
				end
				S_HOLD: begin
					// PD unit keeps its result until the next request starts
					if (out_free) begin
						out_valid_q <= 1'b1;
						steer_q     <= pd_steer;
						locked_q    <= pd_locked;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign steer_command  = steer_q;
	assign heading_locked = locked_q;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking bench for the waypoint heading PD steering core: predictor, driver, monitor.
`timescale 1ns / 1ps

module testbench;
	import whps_pkg::*;

	// predictor constants, taken at the core's default parameters
	localparam int N_ROT = (CORDIC_STEPS_DEF > ROM_SIZE) ? ROM_SIZE : CORDIC_STEPS_DEF;
	localparam int ERR_FB = ERROR_FRAC_DEF;
	localparam longint PI_RAD = PI_Q60;
	localparam longint unsigned DEG_DIVISOR = PI_Q60 >> RND_SHIFT;
	localparam longint PD_ONE = longint'(1) << (GAIN_FRAC + ERR_FB);
	localparam longint LOCK_LIMIT = longint'(2) << ERR_FB;
	localparam longint POS_HI = (longint'(1) << (POS_W - 1)) - 1;
	localparam longint POS_LO = -(longint'(1) << (POS_W - 1));
	// quiet cycles after the last result: one full request latency plus margin
	localparam int SETTLE_CYCLES = CORDIC_STEPS_DEF + ERROR_FRAC_DEF + 30;
	// slowest legal run is a few ms; give it several times that
	localparam int LIMIT_NS = 15_000_000;

	typedef struct packed {
		logic signed [POS_W-1:0]  pose_x;
		logic signed [POS_W-1:0]  pose_y;
		logic signed [HEAD_W-1:0] pose_heading;
		logic signed [POS_W-1:0]  goal_x;
		logic signed [POS_W-1:0]  goal_y;
	} request_t;

	typedef struct packed {
		logic signed [STEER_W-1:0] steer;
		logic                      locked;
	} steer_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [ADDR_W-1:0]  paddr = '0;
	logic [APB_W-1:0]   pwdata = '0;
	logic [APB_W-1:0]   prdata;
	logic               pready;

	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic signed [POS_W-1:0]   pose_x = '0;
	logic signed [POS_W-1:0]   pose_y = '0;
	logic signed [HEAD_W-1:0]  pose_heading = '0;
	logic signed [POS_W-1:0]   goal_x = '0;
	logic signed [POS_W-1:0]   goal_y = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic signed [STEER_W-1:0] steer_command;
	logic                      heading_locked;

	// predictor state: its own copy of the gains and the previous bearing error
	longint unsigned          atan_q60 [ROM_SIZE];
	logic signed [GAIN_W-1:0] prop_gain_q = 16'sd128;
	logic signed [GAIN_W-1:0] deriv_gain_q = 16'sd1536;
	longint                   last_error = 0;

	request_t      pending_requests[$];
	steer_result_t expected_steer[$];
	request_t      request_on_bus = '0;
	bit            holding_request = 1'b0;
	int            send_idle_pct = 0;
	int            recv_stall_pct = 0;
	int            send_gap = 0;
	int            recv_gap = 0;
	int            mismatch_count = 0;
	int            results_seen = 0;

	waypoint_heading_pd_steering_core #(
		.CORDIC_STEPS(CORDIC_STEPS_DEF),
		.ERROR_FRAC_BITS(ERROR_FRAC_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pose_x(pose_x),
		.pose_y(pose_y),
		.pose_heading(pose_heading),
		.goal_x(goal_x),
		.goal_y(goal_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.steer_command(steer_command),
		.heading_locked(heading_locked)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// atan(2^-i) in Q60 from the truncated series x - x^3/3 + x^5/5 ...
	initial begin
		longint unsigned acc;
		longint unsigned term;
		int              sh;
		atan_q60[0] = PI_Q60 >> 2;
		for (int i = 1; i < ROM_SIZE; i++) begin
			acc = 0;
			for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
				sh = i * (2 * k + 1);
				term = (64'd1 << (60 - sh)) / 64'(2 * k + 1);
				if (k % 2 == 1) begin
					acc -= term;
				end else begin
					acc += term;
				end
			end
			atan_q60[i] = acc;
		end
	end

	// Full path for one request: CORDIC bearing minus heading, wrap, degrees, PD,
	// round, saturate, remainder by 360. Updates the stored previous error.
	function automatic steer_result_t compute_steering(input request_t r);
		longint          dx, dy, x, y, z, xs, ys, b, err_deg, u;
		longint unsigned mag, m30, num;
		steer_result_t   res;
		dx = longint'(r.goal_x) - longint'(r.pose_x);
		dy = longint'(r.goal_y) - longint'(r.pose_y);
		b = 0;
		// goal on top of the pose: bearing is zero, heading ignored
		if (dx != 0 || dy != 0) begin
			x = dx;
			y = dy;
			z = 0;
			// left half plane: flip the vector and start from +-pi
			if (x < 0) begin
				x = -x;
				y = -y;
				z = (dy >= 0) ? PI_RAD : -PI_RAD;
			end
			for (int i = 0; i < N_ROT; i++) begin
				xs = y >>> i;
				ys = x >>> i;
				if (y >= 0) begin
					x += xs;
					y -= ys;
					z += longint'(atan_q60[i]);
				end else begin
					x -= xs;
					y += ys;
					z -= longint'(atan_q60[i]);
				end
			end
			b = z - (longint'(r.pose_heading) <<< HEAD_SHIFT);
			if (b > PI_RAD) begin
				b -= 2 * PI_RAD;
			end else if (b <= -PI_RAD) begin
				b += 2 * PI_RAD;
			end
		end
		// magnitude rounded to 30 fraction bits, then scaled to degrees, half up
		mag = (b < 0) ? -b : b;
		m30 = (mag + (64'd1 << (RND_SHIFT - 1))) >> RND_SHIFT;
		num = (m30 * DEG_SCALE) << ERR_FB;
		err_deg = longint'((num + DEG_DIVISOR / 2) / DEG_DIVISOR);
		if (b < 0) begin
			err_deg = -err_deg;
		end
		u = longint'(prop_gain_q) * err_deg + longint'(deriv_gain_q) * (err_deg - last_error);
		u = (u + PD_ONE / 2) / PD_ONE;
		last_error = err_deg;
		if (u > SAT_MAX) begin
			u = SAT_MAX;
		end else if (u < SAT_MIN) begin
			u = SAT_MIN;
		end
		u = u % MOD_DIV;
		res.steer = STEER_W'(u);
		res.locked = (err_deg >= -LOCK_LIMIT) && (err_deg <= LOCK_LIMIT);
		return res;
	endfunction

	// mostly short idle runs, now and then a longer one that can outlast a whole request
	function automatic int idle_run_length();
		return ($urandom_range(15) == 0) ? $urandom_range(120, 20) : 0;
	endfunction

	function automatic logic signed [POS_W-1:0] rand40();
		return POS_W'({$urandom, $urandom});
	endfunction

	function automatic request_t random_request();
		request_t r;
		longint   dx, dy;
		int       mode;
		mode = $urandom_range(99);
		r.pose_heading = HEAD_W'($urandom);
		if (mode < 25) begin
			// anything the fields allow
			r.pose_x = rand40();
			r.pose_y = rand40();
			r.goal_x = rand40();
			r.goal_y = rand40();
		end else begin
			r.pose_x = rand40() >>> 2;
			r.pose_y = rand40() >>> 2;
			if (mode < 35) begin
				dx = 0;
				dy = 0;
			end else if (mode < 55) begin
				// waypoint nearly dead ahead: exercises the lock window
				dx = $urandom_range(1 << 20, 1000);
				dy = longint'($signed($urandom)) % (dx / 16 + 1);
				r.pose_heading = HEAD_W'($urandom_range(600) - 300);
			end else begin
				dx = longint'($signed($urandom)) >>> $urandom_range(31, 8);
				dy = longint'($signed($urandom)) >>> $urandom_range(31, 8);
				if ($urandom_range(7) == 0) begin
					dx = 0;
				end else if ($urandom_range(7) == 0) begin
					dy = 0;
				end
			end
			r.goal_x = POS_W'(longint'(r.pose_x) + dx);
			r.goal_y = POS_W'(longint'(r.pose_y) + dy);
		end
		return r;
	endfunction

	function automatic void push_request(longint px, longint py, longint hd,
			longint gx, longint gy);
		request_t r;
		r.pose_x = POS_W'(px);
		r.pose_y = POS_W'(py);
		r.pose_heading = HEAD_W'(hd);
		r.goal_x = POS_W'(gx);
		r.goal_y = POS_W'(gy);
		pending_requests.push_back(r);
	endfunction

	// Request driver. Prediction happens at the accepting edge so that the
	// previous-error chain follows the order the core takes requests in.
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			expected_steer.push_back(compute_steering(request_on_bus));
			holding_request = 1'b0;
		end
		if (!holding_request) begin
			if (send_gap > 0) begin
				send_gap--;
			end else if (pending_requests.size() != 0) begin
				if ($urandom_range(99) < send_idle_pct) begin
					send_gap = idle_run_length();
				end else begin
					request_on_bus = pending_requests.pop_front();
					holding_request = 1'b1;
				end
			end
		end
		in_valid <= holding_request;
		{pose_x, pose_y, pose_heading, goal_x, goal_y} <= request_on_bus;
	end

	// Result monitor and receiver back-pressure.
	always @(posedge clk) begin : result_check
		steer_result_t want;
		if (out_valid && out_ready) begin
			results_seen++;
			if (expected_steer.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("result %0d: unexpected, steer %0d locked %0b",
						results_seen, steer_command, heading_locked);
				end
			end else begin
				want = expected_steer.pop_front();
				if (steer_command !== want.steer || heading_locked !== want.locked) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("result %0d: steer exp %0d got %0d, locked exp %0b got %0b",
							results_seen, want.steer, steer_command, want.locked,
							heading_locked);
					end
				end
			end
		end
		if (recv_gap > 0) begin
			recv_gap--;
			out_ready <= 1'b0;
		end else if ($urandom_range(99) < recv_stall_pct) begin
			recv_gap = idle_run_length();
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// APB write: setup cycle, access cycle; register takes the value on the access edge
	task automatic write_gain(input reg_idx_t idx, input logic signed [GAIN_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx) << REG_SEL_BIT;
		pwdata <= APB_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_PROP_GAIN) begin
			prop_gain_q = value;
		end else begin
			deriv_gain_q = value;
		end
	endtask

	// wait until every request is taken and every result is back, then let it go quiet
	task automatic settle();
		while (holding_request || pending_requests.size() != 0 || expected_steer.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input int prop, input int deriv, input int send_pct,
			input int recv_pct, input int count);
		write_gain(REG_PROP_GAIN, GAIN_W'(prop));
		write_gain(REG_DERIV_GAIN, GAIN_W'(deriv));
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		for (int n = 0; n < count; n++) begin
			pending_requests.push_back(random_request());
		end
		settle();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed requests at the reset gains, no idling
		// goal on top of the pose, heading at both extremes
		push_request(0, 0, 0, 0, 0);
		push_request(POS_HI, POS_LO, 32767, POS_HI, POS_LO);
		push_request(123456, -98765, -32768, 123456, -98765);
		// straight ahead, straight behind on the axis and just below it
		push_request(0, 0, 0, 1000, 0);
		push_request(0, 0, 0, -1000, 0);
		push_request(0, 0, 0, -1000, -1);
		// behind, heading pushes the bearing over +pi / under -pi
		push_request(0, 0, -8192, -5000, 200);
		push_request(0, 0, 8192, -5000, -200);
		push_request(0, 0, -32768, -100000, 1);
		push_request(0, 0, 32767, -100000, -1);
		// pure +y / -y offsets
		push_request(0, 0, 0, 0, 777);
		push_request(0, 0, 0, 0, -777);
		// largest offsets the position fields allow
		push_request(POS_LO, POS_LO, -32768, POS_HI, POS_HI);
		push_request(POS_HI, POS_HI, 32767, POS_LO, POS_LO);
		push_request(POS_LO, POS_HI, 0, POS_HI, POS_LO);
		push_request(POS_HI, POS_LO, 1, POS_LO, POS_HI);
		// lock window edges, about 2 degrees either way
		push_request(0, 0, 0, 100000, 3491);
		push_request(0, 0, 0, 100000, 3493);
		push_request(0, 0, 0, 100000, -3491);
		push_request(0, 0, 0, 100000, -3493);
		push_request(0, 0, 285, 100000, 0);
		push_request(0, 0, 286, 100000, 0);
		push_request(0, 0, -285, 100000, 0);
		push_request(0, 0, -286, 100000, 0);
		settle();

		// random phases: gain extremes, then mixed settings and idling patterns
		run_phase(-32768, 32767, 76, 0, 110);
		run_phase(32767, -32768, 0, 76, 110);
		run_phase(int'($signed(GAIN_W'($urandom))), int'($signed(GAIN_W'($urandom))),
			38, 38, 110);
		run_phase(256, 0, 0, 0, 110);
		run_phase(128, 1536, 38, 38, 110);

		if (mismatch_count == 0 && expected_steer.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

	initial begin
		#LIMIT_NS;
		$display("testbench NOT OK");
		$finish;
	end

endmodule

// ===== files.f =====
src/whps_pkg.sv
src/whps_cordic.sv
src/whps_deg.sv
src/whps_pd.sv
src/waypoint_heading_pd_steering_core.sv
tb/sv/testbench.sv
